// ----- sv/htg_pkg.sv -----
// ---------------------------------------------------------------------------
// Handle table package
// Types, request and status codes and field layouts shared by the handle
// table modules.
// ---------------------------------------------------------------------------
`default_nettype none

package htg_pkg;

    // Field widths of one request and one result.
    localparam int REQ_W      = 3;
    localparam int HANDLE_W   = 32;
    localparam int HOUT_W     = 31;
    localparam int OBJ_W      = 32;
    localparam int TYPE_W     = 8;
    localparam int RIGHTS_W   = 16;
    localparam int STATUS_W   = 3;
    localparam int ACT_W      = 2;
    localparam int COUNT_W    = 8;
    localparam int NUM_W      = 8;
    localparam int GEN_W      = 23;
    localparam int CFG_IDX_W  = 2;

    // Generation wraps to one after this value.
    localparam logic [GEN_W-1:0] GEN_MAX = 23'd8388607;
    localparam logic [GEN_W-1:0] GEN_ONE = 23'd1;

    // Rights bits that exist at all; install may grant only these.
    localparam int RIGHTS_BITS = 16;
    localparam logic [RIGHTS_W-1:0] RIGHTS_LIMIT =
        (RIGHTS_BITS >= RIGHTS_W) ? {RIGHTS_W{1'b1}}
                                  : RIGHTS_W'((64'd1 << RIGHTS_BITS) - 64'd1);

    // Stream payload widths, padded to whole bytes.
    localparam int IN_TDATA_W  = 120;
    localparam int OUT_TDATA_W = 96;

    // Result field positions in the output tdata.
    localparam int OUT_HOUT_LSB   = 0;
    localparam int OUT_OBJ_LSB    = 31;
    localparam int OUT_RIGHTS_LSB = 63;
    localparam int OUT_ACT_LSB    = 79;
    localparam int OUT_COUNT_LSB  = 81;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_INSTALL = 3'd0;
    localparam logic [REQ_W-1:0] REQ_LOOKUP  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_CLOSE   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DUP     = 3'd3;
    localparam logic [REQ_W-1:0] REQ_TAKE    = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOSLOT    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BADHANDLE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_WRONGTYPE = 3'd4;
    localparam logic [STATUS_W-1:0] ST_ACCESS    = 3'd5;

    // Object reference actions.
    localparam logic [ACT_W-1:0] ACT_NONE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ADD  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DROP = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_RIGHTS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DUP_RIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_XFER_RIGHT   = 2'd2;

    // One request item.
    typedef struct packed {
        logic [REQ_W-1:0]    req_type;
        logic [HANDLE_W-1:0] handle;
        logic [OBJ_W-1:0]    obj_id;
        logic [TYPE_W-1:0]   obj_type;
        logic [RIGHTS_W-1:0] req_rights;
        logic                want_any_type;
        logic [TYPE_W-1:0]   want_type;
        logic [RIGHTS_W-1:0] need_rights;
    } t_req;

    // One result item.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HOUT_W-1:0]   handle_out;
        logic [OBJ_W-1:0]    found_obj;
        logic [RIGHTS_W-1:0] found_rights;
        logic [ACT_W-1:0]    ref_action;
        logic [COUNT_W-1:0]  open_count;
    } t_res;

    // One slot entry as kept in the slot memory.
    typedef struct packed {
        logic [GEN_W-1:0]    gen;
        logic [RIGHTS_W-1:0] rights;
        logic [TYPE_W-1:0]   obj_type;
        logic [OBJ_W-1:0]    obj;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic cap;   // capture the accepted request
        logic rd;    // issue the slot memory read
        logic ex;    // evaluate and commit the first pass
        logic ex2;   // commit the second pass of a duplicate
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;  // output register can take a result this cycle
        logic dup_go;    // duplicate passed its checks and needs a second pass
    } t_stat;

endpackage

`default_nettype wire

// ----- sv/htg_ram.sv -----
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module htg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                                     i_clk,
    input  wire                                     i_we,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire [WIDTH-1:0]                         i_wdata,
    input  wire                                     i_re,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; data holds between reads.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/htg_ctrl.sv -----
// ---------------------------------------------------------------------------
// Handle table controller
// Sequences one request through capture, slot read and commit, with a
// second read and commit pass for a duplicate.
// ---------------------------------------------------------------------------
`default_nettype none

module htg_ctrl
    import htg_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_EX   = 3'd2;
    localparam logic [2:0] S_RD2  = 3'd3;
    localparam logic [2:0] S_EX2  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Commands follow the state; commits wait for room in the output register.
    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        o_cmd.cap  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.rd   = (r_state == S_RD) || (r_state == S_RD2);
        o_cmd.ex   = (r_state == S_EX) && i_stat.out_free;
        o_cmd.ex2  = (r_state == S_EX2) && i_stat.out_free;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_RD;
            end
            S_RD: begin
                n_state = S_EX;
            end
            S_EX: begin
                if (i_stat.out_free) n_state = i_stat.dup_go ? S_RD2 : S_IDLE;
            end
            S_RD2: begin
                n_state = S_EX2;
            end
            S_EX2: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ----- sv/htg_dpath.sv -----
// ---------------------------------------------------------------------------
// Handle table datapath
// Slot memory, valid bits, free slot finder, configuration registers,
// request checks and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module htg_dpath
    import htg_pkg::*;
#(
    parameter int SLOTS = 64
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_wen,
    input  wire [CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire [RIGHTS_W-1:0]   i_cfg_wdata,
    input  t_req                 i_req,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output t_res                 o_res
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Configuration registers.
    logic [RIGHTS_W-1:0] r_valid_rights;
    logic [RIGHTS_W-1:0] r_dup_right;
    logic [RIGHTS_W-1:0] r_xfer_right;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_rights <= {RIGHTS_W{1'b1}};
            r_dup_right    <= RIGHTS_W'(1);
            r_xfer_right   <= RIGHTS_W'(2);
        end else if (i_cfg_wen) begin
            unique case (i_cfg_addr)
                CFG_VALID_RIGHTS: r_valid_rights <= i_cfg_wdata;
                CFG_DUP_RIGHT:    r_dup_right    <= i_cfg_wdata;
                CFG_XFER_RIGHT:   r_xfer_right   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Captured request and duplicate source.
    t_req                r_req;
    logic [OBJ_W-1:0]    r_src_obj;
    logic [TYPE_W-1:0]   r_src_type;
    logic                r_dup2;

    // Slot state held in flops.
    logic [SLOTS-1:0]    r_valid;
    logic [SLOTS-1:0]    r_written;
    logic [COUNT_W-1:0]  r_count;
    logic [SW-1:0]       r_free;
    logic                r_free_ok;
    logic [SW-1:0]       r_addr;

    // Free slot finder: isolate the lowest clear valid bit, then encode it.
    logic [SLOTS-1:0] free_onehot;
    logic [SW-1:0]    free_idx;

    always_comb begin
        free_onehot = ~r_valid & (r_valid + SLOTS'(1));
        free_idx    = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (free_onehot[i]) free_idx = free_idx | SW'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        r_free    <= free_idx;
        r_free_ok <= ~&r_valid;
    end

    // Slot memory read address: free slot for a new entry, else the handle's slot.
    logic [SW-1:0]    rd_addr;
    logic             use_free;

    assign use_free = r_dup2 || (r_req.req_type == REQ_INSTALL);

    always_comb begin
        if (use_free) rd_addr = r_free;
        else          rd_addr = r_req.handle[SW-1:0] - SW'(1);
    end

    // Slot memory.
    t_entry ram_rdata;
    t_entry wr_data;
    logic   wr_en;

    htg_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_addr),
        .i_wdata (wr_data),
        .i_re    (i_cmd.rd),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // Entry as read; an entry never written holds generation one and no rights.
    t_entry ent;

    always_comb begin
        ent = ram_rdata;
        if (!r_written[r_addr]) begin
            ent.gen    = GEN_ONE;
            ent.rights = '0;
        end
    end

    // Handle resolution against the slot just read.
    logic             in_range;
    logic             resolved;
    logic [GEN_W-1:0] gen_next;
    logic             grant_ok;
    logic             excess;
    logic [NUM_W-1:0] hnum;

    assign hnum     = r_req.handle[NUM_W-1:0];
    assign in_range = (hnum != '0) && ({1'b0, hnum} <= (NUM_W + 1)'(SLOTS))
                      && !r_req.handle[HANDLE_W-1];
    assign resolved = in_range && r_valid[r_addr]
                      && (ent.gen == r_req.handle[HANDLE_W-2:NUM_W]);
    assign gen_next = (ent.gen >= GEN_MAX) ? GEN_ONE : ent.gen + GEN_ONE;
    assign grant_ok = (r_req.req_rights & ~(r_valid_rights & RIGHTS_LIMIT)) == '0;
    assign excess   = (r_req.req_rights & ~ent.rights) != '0;

    // Request evaluation.
    t_res n_res;
    logic ev_wr;
    logic ev_set;
    logic ev_clr;
    logic dup_go;

    always_comb begin
        n_res              = '0;
        n_res.status       = ST_INVALID;
        n_res.ref_action   = ACT_NONE;
        wr_data            = ent;
        ev_wr              = 1'b0;
        ev_set             = 1'b0;
        ev_clr             = 1'b0;
        dup_go             = 1'b0;
        if (r_dup2) begin
            // Second pass of a duplicate: place the copy in the free slot.
            n_res.status       = ST_OK;
            n_res.handle_out   = {ent.gen, NUM_W'(r_addr) + NUM_W'(1)};
            n_res.ref_action   = ACT_ADD;
            wr_data.obj        = r_src_obj;
            wr_data.obj_type   = r_src_type;
            wr_data.rights     = r_req.req_rights;
            ev_wr              = 1'b1;
            ev_set             = 1'b1;
        end else begin
            unique case (r_req.req_type)
                REQ_INSTALL: begin
                    if (!grant_ok) begin
                        n_res.status = ST_INVALID;
                    end else if (!r_free_ok) begin
                        n_res.status = ST_NOSLOT;
                    end else begin
                        n_res.status     = ST_OK;
                        n_res.handle_out = {ent.gen, NUM_W'(r_addr) + NUM_W'(1)};
                        n_res.ref_action = ACT_ADD;
                        wr_data.obj      = r_req.obj_id;
                        wr_data.obj_type = r_req.obj_type;
                        wr_data.rights   = r_req.req_rights;
                        ev_wr            = 1'b1;
                        ev_set           = 1'b1;
                    end
                end
                REQ_LOOKUP: begin
                    if (!resolved) begin
                        n_res.status = ST_BADHANDLE;
                    end else if (!r_req.want_any_type && ent.obj_type != r_req.want_type) begin
                        n_res.status = ST_WRONGTYPE;
                    end else if ((ent.rights & r_req.need_rights) != r_req.need_rights) begin
                        n_res.status = ST_ACCESS;
                    end else begin
                        n_res.status       = ST_OK;
                        n_res.found_obj    = ent.obj;
                        n_res.found_rights = ent.rights;
                    end
                end
                REQ_CLOSE: begin
                    if (!resolved) begin
                        n_res.status = ST_BADHANDLE;
                    end else begin
                        n_res.status     = ST_OK;
                        n_res.ref_action = ACT_DROP;
                        wr_data.rights   = '0;
                        wr_data.gen      = gen_next;
                        ev_wr            = 1'b1;
                        ev_clr           = 1'b1;
                    end
                end
                REQ_DUP: begin
                    if (!resolved) begin
                        n_res.status = ST_BADHANDLE;
                    end else if ((ent.rights & r_dup_right) != r_dup_right || excess) begin
                        n_res.status = ST_ACCESS;
                    end else if (!grant_ok) begin
                        n_res.status = ST_INVALID;
                    end else if (!r_free_ok) begin
                        n_res.status = ST_NOSLOT;
                    end else begin
                        dup_go = 1'b1;
                    end
                end
                REQ_TAKE: begin
                    if (!resolved) begin
                        n_res.status = ST_BADHANDLE;
                    end else if ((ent.rights & r_xfer_right) != r_xfer_right || excess) begin
                        n_res.status = ST_ACCESS;
                    end else begin
                        n_res.status    = ST_OK;
                        n_res.found_obj = ent.obj;
                        wr_data.rights  = '0;
                        wr_data.gen     = gen_next;
                        ev_wr           = 1'b1;
                        ev_clr          = 1'b1;
                    end
                end
                default: begin
                    n_res.status = ST_INVALID;
                end
            endcase
        end
    end

    logic commit;
    assign commit = (i_cmd.ex && !dup_go) || i_cmd.ex2;
    assign wr_en  = commit && ev_wr;

    // Open count after this item.
    logic [COUNT_W-1:0] n_count;

    always_comb begin
        n_count = r_count;
        if (ev_set)      n_count = r_count + COUNT_W'(1);
        else if (ev_clr) n_count = r_count - COUNT_W'(1);
    end

    // Request capture, read address and duplicate source.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) r_req <= i_req;
        if (i_cmd.rd)  r_addr <= rd_addr;
        if (i_cmd.ex && dup_go) begin
            r_src_obj  <= ent.obj;
            r_src_type <= ent.obj_type;
        end
    end

    // Control state: valid bits, written bits, count, duplicate pass flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_written <= '0;
            r_count   <= '0;
            r_dup2    <= 1'b0;
        end else begin
            if (i_cmd.ex && dup_go) r_dup2 <= 1'b1;
            else if (i_cmd.ex2)     r_dup2 <= 1'b0;
            if (commit) begin
                r_count <= n_count;
                if (ev_wr)  r_written[r_addr] <= 1'b1;
                if (ev_set) r_valid[r_addr]   <= 1'b1;
                if (ev_clr) r_valid[r_addr]   <= 0;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (commit) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    // Result item with the open count after this item.
    t_res res_d;

    always_comb begin
        res_d            = n_res;
        res_d.open_count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            o_res <= res_d;
        end
    end

    assign o_stat.out_free = !o_out_valid || i_out_ready;
    assign o_stat.dup_go   = dup_go;

endmodule

`default_nettype wire

// ----- sv/handle_table_with_generations_core.sv -----
// ---------------------------------------------------------------------------
// Generational handle table core
// Top level: stream ports, configuration port, controller and datapath.
// ---------------------------------------------------------------------------
// Requests arrive on the s_axis channel, one item per request; results leave
// on the m_axis channel, exactly one item per request, in request order.
// Configuration registers are written through i_cfg_wen/i_cfg_addr/i_cfg_wdata;
// the user must write them only while no request is in flight, as the core
// does not enforce this. A duplicate takes a second slot read and commit pass,
// because the slot memory has one read port and a duplicate reads both the
// source slot and the free slot that receives the copy.
// The result sits in an output register: a new item is accepted while an
// earlier result still waits, and only the commit steps stall while that
// register is still full and m_axis_tready is low.
// Reset clears all valid bits, the open count and the control state at once;
// there is no clearing pass and requests are taken once reset is released.
// ---------------------------------------------------------------------------
`default_nettype none

module handle_table_with_generations_core
    import htg_pkg::*;
#(
    parameter int SLOTS = 64
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // Request channel.
    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata: handle[31:0], obj_id[63:32], obj_type[71:64], req_rights[87:72],
    // want_any_type[88], want_type[96:89], need_rights[112:97], zero fill.
    input  wire [IN_TDATA_W-1:0]   s_axis_tdata,
    // tuser: req_type[2:0].
    input  wire [REQ_W-1:0]        s_axis_tuser,
    // Result channel.
    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready,
    // tdata: handle_out[30:0], found_obj[62:31], found_rights[78:63],
    // ref_action[80:79], open_count[88:81], zero fill.
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // tuser: status[2:0].
    output logic [STATUS_W-1:0]    m_axis_tuser,
    // Configuration write port.
    input  wire                    i_cfg_wen,
    input  wire [CFG_IDX_W-1:0]    i_cfg_addr,
    input  wire [RIGHTS_W-1:0]     i_cfg_wdata
);

    t_req  req;
    t_res  res;
    t_cmd  cmd;
    t_stat stat;

    // Unpack the request item.
    always_comb begin
        req.req_type      = s_axis_tuser;
        req.handle        = s_axis_tdata[31:0];
        req.obj_id        = s_axis_tdata[63:32];
        req.obj_type      = s_axis_tdata[71:64];
        req.req_rights    = s_axis_tdata[87:72];
        req.want_any_type = s_axis_tdata[88];
        req.want_type     = s_axis_tdata[96:89];
        req.need_rights   = s_axis_tdata[112:97];
    end

    htg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    htg_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_res       (res)
    );

    // Pack the result item.
    assign m_axis_tuser = res.status;
    assign m_axis_tdata = {7'b0, res.open_count, res.ref_action, res.found_rights,
                           res.found_obj, res.handle_out};

endmodule

`default_nettype wire

// ----- sv/htg_checker.sv -----
// ---------------------------------------------------------------------------
// Handle table port checker
// Concurrent checks on the top level ports, bound to the core.
// ---------------------------------------------------------------------------
`default_nettype none

module htg_checker
    import htg_pkg::*;
(
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   s_axis_tvalid,
    input wire                   s_axis_tready,
    input wire                   m_axis_tvalid,
    input wire                   m_axis_tready,
    input wire [OUT_TDATA_W-1:0] m_axis_tdata,
    input wire [STATUS_W-1:0]    m_axis_tuser
);

    // A waiting result holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // One request at a time: no acceptance right after an acceptance.
    a_seq_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted back to back");

    // Reference actions only come with a good status.
    a_act_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[OUT_ACT_LSB+ACT_W-1:OUT_ACT_LSB] != ACT_NONE
            |-> m_axis_tuser == ST_OK)
        else $error("reference action with failing status");

    // A new handle never carries slot number zero.
    a_new_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[OUT_ACT_LSB+ACT_W-1:OUT_ACT_LSB] == ACT_ADD
            |-> m_axis_tdata[NUM_W-1:0] != '0)
        else $error("new handle with slot number zero");

    // A failing result reports no handle and no object.
    a_fail_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_OK
            |-> m_axis_tdata[OUT_COUNT_LSB-1:0] == '0)
        else $error("failing result carries payload");

endmodule

bind handle_table_with_generations_core htg_checker u_htg_checker (.*);

`default_nettype wire
